[src/text_console_writer_macros.svh]
// Assertion macros used by the text console writer top level.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define TCW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define TCW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/tcw_pkg.sv]
// Shared types, codes and constants of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   localparam int unsigned CURSOR_OUT_W = 11;

   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] RESET_ATTR = 8'h0F;

   localparam logic [7:0] CODE_BS  = 8'd8;
   localparam logic [7:0] CODE_TAB = 8'd9;
   localparam logic [7:0] CODE_NL  = 8'd10;
   localparam logic [7:0] CODE_CR  = 8'd13;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CH_PRINT = 3'd0,
      CH_BS    = 3'd1,
      CH_TAB   = 3'd2,
      CH_NL    = 3'd3,
      CH_CR    = 3'd4
   } ch_class_type;

   typedef enum logic [2:0] {
      CUR_HOLD = 3'd0,
      CUR_STEP = 3'd1,
      CUR_BACK = 3'd2,
      CUR_LOAD = 3'd3,
      CUR_HOME = 3'd4,
      CUR_MOVE = 3'd5
   } cur_cmd_type;

   typedef enum logic [1:0] {
      SW_INIT   = 2'd0,
      SW_CLEAR  = 2'd1,
      SW_SCROLL = 2'd2
   } sweep_mode_type;

   // Controller to datapath.
   typedef struct packed {
      logic           accept;
      logic           wr_char;
      cur_cmd_type    cur;
      logic           div_start;
      logic           sweep_start;
      sweep_mode_type sweep_mode;
      logic           finish;
      logic           err;
      logic           give_word;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      ch_class_type char_class;
      logic         pos_bad;
      logic         step_wrap;
      logic         move_wrap;
      logic         div_done;
      logic         sweep_done;
   } dp_status_type;

   function automatic ch_class_type classify(input logic [7:0] code);
      ch_class_type cls;
      case (code)
         CODE_BS:  cls = CH_BS;
         CODE_TAB: cls = CH_TAB;
         CODE_NL:  cls = CH_NL;
         CODE_CR:  cls = CH_CR;
         default:  cls = CH_PRINT;
      endcase
      return cls;
   endfunction

endpackage

`default_nettype wire

[src/tcw_rem.sv]
// Remainder by one of two fixed divisors, by reciprocal multiplication and a registered multiply-back.
`timescale 1ns / 1ps
`default_nettype none

module tcw_rem #(
   parameter int DIVIDEND_W = 11,
   parameter int DIV_A      = 80,
   parameter int DIV_B      = 4,
   parameter int REM_W      = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  sel_b,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   output logic                       done,
   output logic [REM_W-1:0]           remainder
);

   // floor(x / d) == (x * ceil(2^(W+L) / d)) >> (W+L) with L = clog2(d), for all x < 2^W
   localparam int SH_A = DIVIDEND_W + $clog2(DIV_A);
   localparam int SH_B = DIVIDEND_W + $clog2(DIV_B);
   localparam int MW   = DIVIDEND_W + 2;
   localparam int PW   = DIVIDEND_W + MW;
   localparam longint unsigned RCP_A_L =
      ((64'd1 << SH_A) + 64'(DIV_A) - 64'd1) / 64'(DIV_A);
   localparam longint unsigned RCP_B_L =
      ((64'd1 << SH_B) + 64'(DIV_B) - 64'd1) / 64'(DIV_B);
   localparam logic [MW-1:0]         RCP_A = MW'(RCP_A_L);
   localparam logic [MW-1:0]         RCP_B = MW'(RCP_B_L);
   // Divisors modulo 2^W: the quotient times the divisor never exceeds the dividend
   localparam logic [DIVIDEND_W-1:0] DEN_A = DIVIDEND_W'(DIV_A);
   localparam logic [DIVIDEND_W-1:0] DEN_B = DIVIDEND_W'(DIV_B);

   logic [DIVIDEND_W-1:0] num_ff;
   logic                  sel_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [REM_W-1:0]      rem_ff;
   logic                  run_ff;
   logic                  quo_vld_ff;
   logic                  done_ff;

   logic [PW-1:0]         prod_a;
   logic [PW-1:0]         prod_b;
   logic [DIVIDEND_W-1:0] quo_in;
   logic [DIVIDEND_W-1:0] back;
   logic [DIVIDEND_W-1:0] rem_full;

   always_comb begin
      prod_a   = PW'(num_ff) * PW'(RCP_A);
      prod_b   = PW'(num_ff) * PW'(RCP_B);
      quo_in   = sel_ff ? DIVIDEND_W'(prod_b >> SH_B) : DIVIDEND_W'(prod_a >> SH_A);
      back     = quo_ff * (sel_ff ? DEN_B : DEN_A);
      rem_full = num_ff - back;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         quo_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         run_ff     <= start;
         quo_vld_ff <= run_ff;
         done_ff    <= quo_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         sel_ff <= sel_b;
      end
      if (run_ff) quo_ff <= quo_in;
      if (quo_vld_ff) rem_ff <= REM_W'(rem_full);
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[src/tcw_ctrl.sv]
// Controller state machine of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [1:0]    op,
   input  wire dp_status_type status,
   output logic               busy,
   output ctl_cmd_type        cmd
);

   typedef enum logic [4:0] {
      ST_WIPE   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_READ   = 5'b01000,
      ST_SWEEP  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.cur        = CUR_HOLD;
      cmd.sweep_mode = SW_SCROLL;
      case (state_ff)
         ST_WIPE: begin
            if (status.sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               case (op_type'(op))
                  OP_PUT: begin
                     case (status.char_class)
                        CH_PRINT: begin
                           cmd.wr_char = 1'b1;
                           cmd.cur     = CUR_STEP;
                           if (status.step_wrap) begin
                              cmd.sweep_start = 1'b1;
                              state_in        = ST_SWEEP;
                           end else begin
                              cmd.finish = 1'b1;
                           end
                        end
                        CH_BS: begin
                           cmd.cur    = CUR_BACK;
                           cmd.finish = 1'b1;
                        end
                        default: begin
                           cmd.div_start = 1'b1;
                           state_in      = ST_DIVIDE;
                        end
                     endcase
                  end
                  OP_SET: begin
                     cmd.finish = 1'b1;
                     if (status.pos_bad) cmd.err = 1'b1;
                     else cmd.cur = CUR_LOAD;
                  end
                  OP_CLEAR: begin
                     cmd.cur         = CUR_HOME;
                     cmd.sweep_start = 1'b1;
                     cmd.sweep_mode  = SW_CLEAR;
                     state_in        = ST_SWEEP;
                  end
                  default: begin
                     if (status.pos_bad) begin
                        cmd.finish = 1'b1;
                        cmd.err    = 1'b1;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.cur = CUR_MOVE;
               if (status.move_wrap) begin
                  cmd.sweep_start = 1'b1;
                  state_in        = ST_SWEEP;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            cmd.finish    = 1'b1;
            cmd.give_word = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SWEEP: begin
            if (status.sweep_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_WIPE;
      else state_ff <= state_in;
   end

   assign busy = state_ff != ST_IDLE;

endmodule

`default_nettype wire

[src/tcw_dp.sv]
// Datapath of the text console writer: cell store, cursor, sweep and replies.
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp import tcw_pkg::*; #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctl_cmd_type             cmd,
   output dp_status_type                status,
   input  wire logic [7:0]              char_code,
   input  wire logic [15:0]             position,
   input  wire logic                    attr_we,
   input  wire logic [7:0]              attr_data,
   output logic                         rsp_valid,
   output logic [15:0]                  rsp_cell_word,
   output logic [CURSOR_OUT_W-1:0]      rsp_cursor,
   output logic                         rsp_status
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int NW    = AW + 1;
   localparam int DMAX  = (COLUMNS > TAB_WIDTH) ? COLUMNS : TAB_WIDTH;
   localparam int DW    = $clog2(DMAX + 1);

   logic [15:0]    mem [0:CELLS-1];

   logic [7:0]     attr_ff;
   logic [7:0]     chr_ff;
   logic [AW-1:0]  cursor_ff;
   logic [AW-1:0]  cursor_in;

   logic           sweep_active_ff;
   logic [AW-1:0]  sweep_idx_ff;
   sweep_mode_type sweep_mode_ff;
   logic           wr_pend_ff;
   logic [AW-1:0]  wr_addr_ff;
   logic           wr_copy_ff;
   logic           wr_init_ff;
   logic [15:0]    wr_word;

   logic [AW-1:0]  rd_addr;
   logic [15:0]    rd_data_ff;

   logic           rsp_valid_ff;
   logic [15:0]    rsp_word_ff;
   logic [CURSOR_OUT_W-1:0] rsp_cursor_ff;
   logic           rsp_status_ff;
   logic [31:0]    cursor_wide;

   logic [NW-1:0]  cur_n;
   logic [NW-1:0]  step_nxt;
   logic [NW-1:0]  mv_base;
   logic [NW-1:0]  mv_nxt;
   logic           in_copy;
   logic           pos_bad;

   logic           div_done;
   logic [DW-1:0]  div_rem;
   logic           div_sel_tab;

   function automatic logic [AW-1:0] wrap_fix(input logic [NW-1:0] nxt);
      logic [NW-1:0] adj;
      adj = nxt - NW'(COLUMNS);
      if (nxt < NW'(CELLS)) return nxt[AW-1:0];
      else if (adj >= NW'(CELLS)) return AW'(CELLS - 1);
      else return adj[AW-1:0];
   endfunction

   tcw_rem #(
      .DIVIDEND_W (AW),
      .DIV_A      (COLUMNS),
      .DIV_B      (TAB_WIDTH),
      .REM_W      (DW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .sel_b     (div_sel_tab),
      .dividend  (cursor_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      div_sel_tab = classify(char_code) == CH_TAB;
      pos_bad     = {1'b0, position} >= 17'(CELLS);
      cur_n       = {1'b0, cursor_ff};
      step_nxt    = cur_n + NW'(1);
      mv_base     = cur_n - NW'(div_rem);
      case (classify(chr_ff))
         CH_NL:   mv_nxt = mv_base + NW'(COLUMNS);
         CH_TAB:  mv_nxt = mv_base + NW'(TAB_WIDTH);
         default: mv_nxt = mv_base;
      endcase
   end

   always_comb begin
      case (cmd.cur)
         CUR_STEP: cursor_in = wrap_fix(step_nxt);
         CUR_BACK: cursor_in = (cursor_ff == '0) ? cursor_ff : cursor_ff - AW'(1);
         CUR_LOAD: cursor_in = position[AW-1:0];
         CUR_HOME: cursor_in = '0;
         CUR_MOVE: cursor_in = wrap_fix(mv_nxt);
         default:  cursor_in = cursor_ff;
      endcase
   end

   always_comb begin
      status.char_class = classify(char_code);
      status.pos_bad    = pos_bad;
      status.step_wrap  = step_nxt >= NW'(CELLS);
      status.move_wrap  = mv_nxt >= NW'(CELLS);
      status.div_done   = div_done;
      status.sweep_done = wr_pend_ff && (wr_addr_ff == AW'(CELLS - 1));
   end

   // Sweep: issue one read per cycle, and write each cell in the cycle after its read.
   always_comb begin
      in_copy = (sweep_mode_ff == SW_SCROLL) && (NW'(sweep_idx_ff) < NW'(CELLS - COLUMNS));
      if (sweep_active_ff) begin
         rd_addr = in_copy ? AW'(NW'(sweep_idx_ff) + NW'(COLUMNS)) : '0;
      end else begin
         rd_addr = pos_bad ? '0 : position[AW-1:0];
      end
      if (wr_copy_ff) wr_word = rd_data_ff;
      else wr_word = {(wr_init_ff ? RESET_ATTR : attr_ff), BLANK_CHAR};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_active_ff <= 1'b1;
         sweep_idx_ff    <= '0;
         sweep_mode_ff   <= SW_INIT;
         wr_pend_ff      <= 1'b0;
      end else begin
         wr_pend_ff <= sweep_active_ff;
         if (cmd.sweep_start) begin
            sweep_active_ff <= 1'b1;
            sweep_idx_ff    <= '0;
            sweep_mode_ff   <= cmd.sweep_mode;
         end else if (sweep_active_ff) begin
            sweep_idx_ff <= sweep_idx_ff + AW'(1);
            if (sweep_idx_ff == AW'(CELLS - 1)) sweep_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= sweep_idx_ff;
      wr_copy_ff <= sweep_active_ff && in_copy;
      wr_init_ff <= sweep_mode_ff == SW_INIT;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_char) mem[cursor_ff] <= {attr_ff, char_code};
      else if (wr_pend_ff) mem[wr_addr_ff] <= wr_word;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff   <= RESET_ATTR;
         cursor_ff <= '0;
      end else begin
         if (attr_we) attr_ff <= attr_data;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) chr_ff <= char_code;
   end

   assign cursor_wide = 32'(cursor_in);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_word_ff   <= cmd.give_word ? rd_data_ff : 16'h0000;
         rsp_cursor_ff <= cursor_wide[CURSOR_OUT_W-1:0];
         rsp_status_ff <= cmd.err;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_word = rsp_word_ff;
   assign rsp_cursor    = rsp_cursor_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

[src/text_console_writer.sv]
// Top level of the text console writer: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_macros.svh"

// Text-mode console engine holding a COLUMNS x ROWS store of 16-bit cells
// (attribute high byte, character low byte) and a cursor. Raise start with
// req_op, req_char_code and req_position while busy is low; the word is taken
// at that edge. Every word yields exactly one reply, shown on the rsp_ ports
// for a single cycle while rsp_valid is high: the receiver cannot stall, so
// capture it then. Each kind of word is sequenced around the cell store's single
// read and single write port and the two-stage reciprocal remainder unit:
//   printable character, backspace, set cursor, bad read cell: replied from decode;
//   read cell: waits in a read state (registered store read);
//   newline, carriage return, tab: the column or tab phase comes from a
//     registered reciprocal multiply followed by a registered multiply-back;
//   clear screen, and a printable character that scrolls: the store is swept
//     one cell per cycle (a scroll copies up one row, then blanks the last row;
//     a clear blanks every cell); a newline or tab that scrolls does both steps.
// After reset the store is blanked by the same sweep, with busy high; the
// attribute register (csr_ port, always ready) may be written meanwhile, but
// write it only between words otherwise.
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_op,
   input  wire logic [7:0]               req_char_code,
   input  wire logic [15:0]              req_position,
   output logic                          rsp_valid,
   output logic [15:0]                   rsp_cell_word,
   output logic [CURSOR_OUT_W-1:0]       rsp_cursor,
   output logic                          rsp_status,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [7:0]               csr_text_attr
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Sequence each word: decode, start the remainder unit or a sweep, reply.
   tcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .op     (req_op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // Hold the store, cursor and attribute; advance the sweep; drive replies.
   tcw_dp #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .char_code     (req_char_code),
      .position      (req_position),
      .attr_we       (csr_valid && csr_ready),
      .attr_data     (csr_text_attr),
      .rsp_valid     (rsp_valid),
      .rsp_cell_word (rsp_cell_word),
      .rsp_cursor    (rsp_cursor),
      .rsp_status    (rsp_status)
   );

   // The attribute register never holds a write off.
   assign csr_ready = 1'b1;

   // A character lands in the store only on an accepted word.
   `TCW_ASSERT_IMP(a_char_on_accept, clock, reset, cmd.wr_char, start && !busy, "char write outside accept")
   // A valid read cell needs the store's read latency before its reply.
   `TCW_ASSERT_NXT(a_read_waits, clock, reset, start && !busy && req_op == OP_READ && !status.pos_bad, !rsp_valid, "read cell replied too early")
   // An error reply comes only from set cursor or read cell, with an empty cell word.
   `TCW_ASSERT_IMP(a_err_source, clock, reset, rsp_valid && rsp_status, ($past(req_op) == OP_SET || $past(req_op) == OP_READ) && rsp_cell_word == 16'h0000, "bad error reply")

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the text console writer.
`timescale 1ns / 1ps

module tb;
   import tcw_pkg::*;

   // Screen geometry: keep in step with the parameters handed to the DUT
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TAB_WIDTH = 4;
   localparam int CELLS     = COLUMNS * ROWS;

   // Reply status codes
   localparam logic ST_DONE  = 1'b0;
   localparam logic ST_RANGE = 1'b1;

   // Random words per idling phase, and a hard stop well beyond the slowest legal run
   localparam int PHASE_WORDS = 200;
   localparam int TIMEOUT_NS  = 20_000_000;

   // One entry of the driver's backlog: either a command word or an attribute write
   typedef struct {
      bit          is_attr;
      op_type      op;
      logic [7:0]  code;
      logic [15:0] pos;
      logic [7:0]  attr;
      int unsigned idle_pct;
   } console_cmd_type;

   typedef struct {
      logic [15:0]             cell_word;
      logic [CURSOR_OUT_W-1:0] cursor;
      logic                    status;
   } console_reply_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_op = 2'd0;
   logic [7:0]              req_char_code = 8'd0;
   logic [15:0]             req_position = 16'd0;
   logic                    rsp_valid;
   logic [15:0]             rsp_cell_word;
   logic [CURSOR_OUT_W-1:0] rsp_cursor;
   logic                    rsp_status;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [7:0]              csr_text_attr = 8'd0;

   // Shadow copy of the console: screen cells, cursor and current attribute
   logic [15:0]    screen_cells [0:CELLS-1];
   int unsigned    cursor_at;
   logic [7:0]     attr_now;

   console_cmd_type   pending_cmds [$];
   console_reply_type expected_replies [$];

   int unsigned    fail_count;
   int unsigned    op_count [4];
   int unsigned    range_count;
   int unsigned    scroll_count;
   int unsigned    attr_writes;
   int unsigned    replies_seen;

   text_console_writer #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_WIDTH(TAB_WIDTH)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_char_code(req_char_code),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_cell_word(rsp_cell_word),
      .rsp_cursor   (rsp_cursor),
      .rsp_status   (rsp_status),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_text_attr(csr_text_attr)
   );

   always #1 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Fill a run of cells with blanks in the current attribute
   function automatic void blank_cells(input int unsigned from, input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++)
         if (from + i < CELLS) screen_cells[from + i] = {attr_now, BLANK_CHAR};
   endfunction

   // Apply one accepted command word to the shadow console and queue its reply
   function automatic void apply_console_cmd(input op_type op, input logic [7:0] code,
                                             input logic [15:0] pos);
      console_reply_type rep;
      int unsigned    i;
      rep.cell_word = 16'd0;
      rep.status    = ST_DONE;
      op_count[op]++;
      case (op)
         OP_PUT: begin
            case (code)
               CODE_NL:  cursor_at = (cursor_at / COLUMNS + 1) * COLUMNS;
               CODE_CR:  cursor_at = cursor_at - cursor_at % COLUMNS;
               CODE_TAB: cursor_at = cursor_at - cursor_at % TAB_WIDTH + TAB_WIDTH;
               CODE_BS: begin
                  // backspace stops at the first cell and never erases
                  if (cursor_at > 0) cursor_at = cursor_at - 1;
               end
               default: begin
                  if (cursor_at < CELLS) screen_cells[cursor_at] = {attr_now, code};
                  cursor_at = cursor_at + 1;
               end
            endcase
            // Off the end: shift everything up a row, blank the bottom row, step back a row
            if (cursor_at >= CELLS) begin
               for (i = 0; i < CELLS - COLUMNS; i++)
                  screen_cells[i] = screen_cells[i + COLUMNS];
               blank_cells(CELLS - COLUMNS, COLUMNS);
               cursor_at = cursor_at - COLUMNS;
               if (cursor_at >= CELLS) cursor_at = CELLS - 1;
               scroll_count++;
            end
         end
         OP_SET: begin
            if (pos >= CELLS) rep.status = ST_RANGE;
            else cursor_at = {16'd0, pos};
         end
         OP_CLEAR: begin
            blank_cells(0, CELLS);
            cursor_at = 0;
         end
         default: begin
            if (pos >= CELLS) rep.status = ST_RANGE;
            else rep.cell_word = screen_cells[pos];
         end
      endcase
      if (rep.status == ST_RANGE) range_count++;
      rep.cursor = cursor_at[CURSOR_OUT_W-1:0];
      expected_replies.push_back(rep);
   endfunction

   function automatic void queue_cmd(input op_type op, input logic [7:0] code,
                                     input logic [15:0] pos, input int unsigned idle_pct);
      console_cmd_type c;
      c.is_attr  = 1'b0;
      c.op       = op;
      c.code     = code;
      c.pos      = pos;
      c.attr     = 8'd0;
      c.idle_pct = idle_pct;
      pending_cmds.push_back(c);
   endfunction

   function automatic void queue_attr(input logic [7:0] value);
      console_cmd_type c;
      c.is_attr  = 1'b1;
      c.op       = OP_PUT;
      c.code     = 8'd0;
      c.pos      = 16'd0;
      c.attr     = value;
      c.idle_pct = 0;
      pending_cmds.push_back(c);
   endfunction

   // Random word, weighted so that the cursor wanders to the bottom of the screen
   // often enough to scroll, while clears (each a full-screen sweep) stay rare
   function automatic void queue_random_cmd(input int unsigned idle_pct);
      int unsigned pick;
      int unsigned sel;
      logic [7:0]  code;
      logic [15:0] pos;
      pick = $urandom_range(99);
      sel  = $urandom_range(9);
      code = 8'($urandom_range(255));
      pos  = 16'($urandom_range(65535));
      if (pick < 60) begin
         if ($urandom_range(99) < 20) begin
            case ($urandom_range(3))
               0:       code = CODE_BS;
               1:       code = CODE_TAB;
               2:       code = CODE_NL;
               default: code = CODE_CR;
            endcase
         end
         queue_cmd(OP_PUT, code, pos, idle_pct);
      end else if (pick < 72) begin
         if (sel < 3) pos = 16'($urandom_range(CELLS - 1, CELLS - COLUMNS));
         else if (sel < 7) pos = 16'($urandom_range(CELLS - 1));
         queue_cmd(OP_SET, code, pos, idle_pct);
      end else if (pick < 74) begin
         queue_cmd(OP_CLEAR, code, pos, idle_pct);
      end else begin
         if (sel < 8) pos = 16'($urandom_range(CELLS - 1));
         queue_cmd(OP_READ, code, pos, idle_pct);
      end
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 40)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // Driver: take words off the backlog, hold each until busy drops, and feed every
   // accepted word to the shadow console at the edge that takes it
   always @(posedge clock) begin
      bit cmd_taken;
      bit attr_taken;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         cmd_taken  = start && !busy;
         attr_taken = csr_valid && csr_ready;
         if (cmd_taken) apply_console_cmd(op_type'(req_op), req_char_code, req_position);
         if (attr_taken) begin
            attr_now = csr_text_attr;
            attr_writes++;
         end
         if ((start && !cmd_taken) || (csr_valid && !attr_taken)) begin
            // hold: the word on the port has not been taken yet
         end else if (pending_cmds.size() == 0) begin
            start     <= 1'b0;
            csr_valid <= 1'b0;
         end else if (pending_cmds[0].is_attr) begin
            start <= 1'b0;
            // Write the attribute only with the console drained: no reply owed, none
            // on the port this cycle, and the engine not busy
            if (!cmd_taken && expected_replies.size() == 0 && !rsp_valid && !busy) begin
               csr_valid     <= 1'b1;
               csr_text_attr <= pending_cmds[0].attr;
               void'(pending_cmds.pop_front());
            end else begin
               csr_valid <= 1'b0;
            end
         end else begin
            csr_valid <= 1'b0;
            if ($urandom_range(99) < pending_cmds[0].idle_pct) begin
               start <= 1'b0;
            end else begin
               start         <= 1'b1;
               req_op        <= pending_cmds[0].op;
               req_char_code <= pending_cmds[0].code;
               req_position  <= pending_cmds[0].pos;
               void'(pending_cmds.pop_front());
            end
         end
      end
   end

   // Monitor: each strobed reply must match the oldest outstanding prediction
   always @(posedge clock) begin
      console_reply_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= 40)
               $display("%0t: unexpected reply: expected none, got cell %0h cursor %0d status %0d",
                        $time, rsp_cell_word, rsp_cursor, rsp_status);
         end else begin
            want = expected_replies.pop_front();
            check_field("cell_word", want.cell_word, rsp_cell_word);
            check_field("cursor", {5'd0, want.cursor}, {5'd0, rsp_cursor});
            check_field("status", {15'd0, want.status}, {15'd0, rsp_status});
            replies_seen++;
         end
      end
   end

   // Stimulus: build the whole backlog up front, then wait for the console to drain
   initial begin
      int unsigned phase;
      int unsigned n;
      int unsigned idle_pct;
      logic [7:0]  phase_attr;

      attr_now  = RESET_ATTR;
      blank_cells(0, CELLS);
      cursor_at = 0;

      // Directed: reset contents, both ends of the address range, every control code
      queue_cmd(OP_READ, 8'd0, 16'd0, 0);
      queue_cmd(OP_READ, 8'hFF, 16'(CELLS - 1), 0);
      queue_cmd(OP_READ, 8'd0, 16'(CELLS), 0);
      queue_cmd(OP_READ, 8'd0, 16'hFFFF, 0);
      queue_cmd(OP_PUT, CODE_BS, 16'hFFFF, 0);   // backspace on the first cell
      queue_cmd(OP_PUT, 8'h41, 16'd0, 0);
      queue_cmd(OP_PUT, 8'h00, 16'd0, 0);
      queue_cmd(OP_PUT, 8'hFF, 16'd0, 0);
      queue_cmd(OP_PUT, CODE_TAB, 16'd0, 0);
      queue_cmd(OP_PUT, CODE_BS, 16'd0, 0);
      queue_cmd(OP_PUT, CODE_CR, 16'd0, 0);
      queue_cmd(OP_PUT, CODE_NL, 16'd0, 0);
      queue_cmd(OP_READ, 8'd0, 16'd0, 0);
      queue_cmd(OP_SET, 8'd0, 16'(CELLS - 1), 0);
      queue_cmd(OP_SET, 8'd0, 16'(CELLS), 0);    // just past the screen: rejected
      queue_cmd(OP_SET, 8'd0, 16'hFFFF, 0);

      // Full attribute, then force scrolls from a printable, a tab and a newline
      queue_attr(8'hFF);
      queue_cmd(OP_PUT, 8'h5A, 16'd0, 0);
      queue_cmd(OP_READ, 8'd0, 16'(CELLS - COLUMNS - 1), 0);
      queue_cmd(OP_READ, 8'd0, 16'(CELLS - 1), 0);
      queue_cmd(OP_SET, 8'd0, 16'(CELLS - 2), 0);
      queue_cmd(OP_PUT, CODE_TAB, 16'd0, 0);
      queue_cmd(OP_SET, 8'd0, 16'(CELLS - COLUMNS + 30), 0);
      queue_cmd(OP_PUT, CODE_NL, 16'd0, 0);
      queue_cmd(OP_PUT, CODE_CR, 16'd0, 0);
      queue_cmd(OP_CLEAR, 8'd0, 16'd0, 0);
      queue_cmd(OP_READ, 8'd0, 16'd0, 0);

      // Random phases: no gaps, heavy sender gaps, no gaps again, light sender gaps.
      // The reply side cannot stall, so only the sender idles.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  phase_attr = 8'h00; end
            1:       begin idle_pct = 74; phase_attr = 8'($urandom_range(255)); end
            2:       begin idle_pct = 0;  phase_attr = 8'hFF; end
            default: begin idle_pct = 20; phase_attr = 8'($urandom_range(255)); end
         endcase
         queue_attr(phase_attr);
         for (n = 0; n < PHASE_WORDS; n++) queue_random_cmd(idle_pct);
      end

      // Sample at the falling edge so that the driver's and monitor's updates have settled
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || csr_valid || expected_replies.size() != 0);
      // Keep the clock running to show any stray reply
      repeat (CELLS + 16) @(negedge clock);

      $display("Covered %0d words: %0d put, %0d set cursor, %0d clear, %0d read cell",
               replies_seen, op_count[OP_PUT], op_count[OP_SET], op_count[OP_CLEAR],
               op_count[OP_READ]);
      $display("with %0d scrolls, %0d out-of-range positions and %0d attribute writes",
               scroll_count, range_count, attr_writes);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout: %0d words unsent, %0d replies outstanding",
               pending_cmds.size(), expected_replies.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
